// ===== rtl/core/rdcrc_pkg.sv =====
// Package: shared types and constants for the record deframer with CRC check.
package rdcrc_pkg;

  localparam logic [15:0] HeaderIdV2 = 16'h5244;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_EXTRA   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OPEN      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_CRC_BAD   = 3'd2,
    ST_UNVERIF   = 3'd3,
    ST_BAD_HDR   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_e;

  // Item handed from the parser to the finishing stage.
  typedef struct packed {
    logic [7:0]  data;
    logic        has_byte;
    logic        is_extra;
    logic        done;
    logic        bad_hdr;
    logic        trunc;
    logic        verdict_req;
    logic [1:0]  version;
    logic [31:0] crypto;
    logic [31:0] payload_len;
    logic [31:0] crc_field;
    logic [31:0] extra_len;
    logic [31:0] crc_prev;
    logic [31:0] rec_len;
  } work_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        is_extra;
    logic        record_done;
    logic [2:0]  status;
    logic [1:0]  format_version;
    logic [31:0] crypto_word;
    logic [31:0] payload_length;
    logic [31:0] extra_length;
    logic [31:0] record_length;
  } result_t;

  // Advance a reflected CRC-32 by one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rdcrc_if.sv =====
// Interfaces: valid/ready channels for stream bytes and record results.
interface rdcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface rdcrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        is_extra;
  logic        record_done;
  logic [2:0]  status;
  logic [1:0]  format_version;
  logic [31:0] crypto_word;
  logic [31:0] payload_length;
  logic [31:0] extra_length;
  logic [31:0] record_length;
  modport source (output valid, output out_byte, output has_byte, output is_extra,
                  output record_done, output status, output format_version,
                  output crypto_word, output payload_length, output extra_length,
                  output record_length, input ready);
  modport sink (input valid, input out_byte, input has_byte, input is_extra,
                input record_done, input status, input format_version,
                input crypto_word, input payload_length, input extra_length,
                input record_length, output ready);
endinterface

// ===== rtl/core/rdcrc_front.sv =====
// Front end: header parser and record sequencer, emits one work item per result.
module rdcrc_front import rdcrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_end_i,
  output logic        in_ready_o,
  output logic        w_valid_o,
  output work_t       w_data_o,
  input  logic        w_ready_i
);

  phase_e      phase_q, phase_d;
  logic [4:0]  hcnt_q, hcnt_d;
  logic [31:0] shift_q, shift_d;
  logic [1:0]  ver_q, ver_d;
  logic [31:0] crypto_q, crypto_d, plen_q, plen_d, crc_q, crc_d, xlen_q, xlen_d;
  logic [31:0] left_q, left_d, rcrc_q, rcrc_d, cnt_q, cnt_d;
  logic        take;
  logic        has, isx, done, bad, trunc, vreq;
  logic [1:0]  k;

  // Accept whenever the queue has room.
  assign in_ready_o = w_ready_i;
  assign take       = in_valid_i & w_ready_i;
  assign w_valid_o  = take & (has | done);

  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; shift_d = shift_q; ver_d = ver_q;
    crypto_d = crypto_q; plen_d = plen_q; crc_d = crc_q; xlen_d = xlen_q;
    left_d = left_q; rcrc_d = rcrc_q;
    cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
    has = 1'b0; isx = 1'b0; done = 1'b0; bad = 1'b0; trunc = 1'b0; vreq = 1'b0;
    k = 2'd0;
    if (phase_q != PH_HEADER) begin
      has = 1'b1;
      isx = (phase_q == PH_EXTRA);
      if (!isx) rcrc_d = crc_byte(rcrc_q, in_byte_i);
      left_d = left_q - 32'd1;
      if (left_q == 32'd1) begin
        if (!isx && xlen_q != '0) begin
          phase_d = PH_EXTRA;
          left_d  = xlen_q;
        end else begin
          done = 1'b1; vreq = 1'b1;
        end
      end
    end else begin
      shift_d = {in_byte_i, shift_q[31:8]};
      hcnt_d  = hcnt_q + 5'd1;
      if (hcnt_d == 5'd4) begin
        if (shift_d[15:0] == HeaderIdV2 && shift_d[31:16] == 16'd2) ver_d = 2'd2;
        else if (shift_d[15:0] == 16'd1) ver_d = 2'd1;
        else begin
          done = 1'b1; bad = 1'b1;
        end
      end else if (hcnt_d >= 5'd8 && hcnt_d[1:0] == 2'b00) begin
        k = hcnt_d[3:2] - 2'd2 + ((ver_q == 2'd1) ? 2'd1 : 2'd0);
        case (k)
          2'd0: crypto_d = shift_d;
          2'd1: plen_d = shift_d;
          2'd2: crc_d = shift_d;
          default: begin
            xlen_d = shift_d;
            if (plen_q != '0) begin
              phase_d = PH_PAYLOAD; left_d = plen_q;
            end else if (shift_d != '0) begin
              phase_d = PH_EXTRA; left_d = shift_d;
            end else begin
              done = 1'b1; vreq = 1'b1;
            end
          end
        endcase
      end
    end
    if (!done && in_end_i) begin
      done = 1'b1; trunc = 1'b1;
    end
  end

  // Build the work item from updated record fields and the CRC before this byte.
  always_comb begin
    w_data_o.data        = in_byte_i;
    w_data_o.has_byte    = has;
    w_data_o.is_extra    = isx;
    w_data_o.done        = done;
    w_data_o.bad_hdr     = bad;
    w_data_o.trunc       = trunc;
    w_data_o.verdict_req = vreq;
    w_data_o.version     = ver_d;
    w_data_o.crypto      = crypto_d;
    w_data_o.payload_len = plen_d;
    w_data_o.crc_field   = crc_d;
    w_data_o.extra_len   = xlen_d;
    w_data_o.crc_prev    = rcrc_q;
    w_data_o.rec_len     = cnt_d;
  end

  // Advance state on each accepted byte; clear after a record closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hcnt_q <= '0; shift_q <= '0; ver_q <= '0;
      crypto_q <= '0; plen_q <= '0; crc_q <= '0; xlen_q <= '0;
      left_q <= '0; rcrc_q <= '1; cnt_q <= '0;
    end else if (take) begin
      if (done) begin
        phase_q <= PH_HEADER; hcnt_q <= '0; shift_q <= '0; ver_q <= '0;
        crypto_q <= '0; plen_q <= '0; crc_q <= '0; xlen_q <= '0;
        left_q <= '0; rcrc_q <= '1; cnt_q <= '0;
      end else begin
        phase_q <= phase_d; hcnt_q <= hcnt_d; shift_q <= shift_d; ver_q <= ver_d;
        crypto_q <= crypto_d; plen_q <= plen_d; crc_q <= crc_d; xlen_q <= xlen_d;
        left_q <= left_d; rcrc_q <= rcrc_d; cnt_q <= cnt_d;
      end
    end
  end

endmodule

// ===== rtl/core/rdcrc_queue.sv =====
// Queue: two-entry FIFO between parser and finishing stage.
module rdcrc_queue import rdcrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  ready_o,
  output logic  valid_o,
  output work_t pop_data_o,
  input  logic  pop_i
);

  work_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  // Track pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/core/rdcrc_back.sv =====
// Back end: CRC finish, verdict and registered result output.
module rdcrc_back import rdcrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    w_valid_i,
  input  work_t   w_data_i,
  output logic    w_ready_o,
  output logic    r_valid_o,
  output result_t r_data_o,
  input  logic    r_ready_i
);

  logic        valid_q;
  result_t     res_q, res_d;
  logic [31:0] crc_fin;
  status_e     st;

  assign w_ready_o = !valid_q || r_ready_i;
  assign r_valid_o = valid_q;
  assign r_data_o  = res_q;

  // Fold the last byte into the CRC and pick the status.
  always_comb begin
    crc_fin = w_data_i.crc_prev;
    if (w_data_i.has_byte && !w_data_i.is_extra)
      crc_fin = crc_byte(w_data_i.crc_prev, w_data_i.data);
    st = ST_OPEN;
    if (w_data_i.bad_hdr) st = ST_BAD_HDR;
    else if (w_data_i.trunc) st = ST_TRUNCATED;
    else if (w_data_i.verdict_req) begin
      if (w_data_i.payload_len == '0 || w_data_i.crc_field == '0) st = ST_UNVERIF;
      else if (~crc_fin == w_data_i.crc_field) st = ST_GOOD;
      else st = ST_CRC_BAD;
    end
    res_d.out_byte       = w_data_i.has_byte ? w_data_i.data : 8'd0;
    res_d.has_byte       = w_data_i.has_byte;
    res_d.is_extra       = w_data_i.is_extra;
    res_d.record_done    = w_data_i.done;
    res_d.status         = st;
    res_d.format_version = w_data_i.bad_hdr ? 2'd0 : w_data_i.version;
    res_d.crypto_word    = w_data_i.crypto;
    res_d.payload_length = w_data_i.payload_len;
    res_d.extra_length   = w_data_i.extra_len;
    res_d.record_length  = w_data_i.rec_len;
  end

  // Hold the payload until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (w_valid_i && w_ready_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (w_ready_o) valid_q <= w_valid_i;
  end

endmodule

// ===== rtl/core/record_deframer_crc_check.sv =====
// Top level: record deframer with CRC-32 check.
//
//  channel | dir | payload
//  in_s    | in  | in_byte, stream_end
//  out_m   | out | out_byte .. record_length (one result per transaction)
//
// One byte is taken per cycle while the queue has room; header parsing and the
// next-state CRC run in the parser, the final CRC compare in the output stage.
// A byte's work item enters the queue on its accepting edge and its result is
// then registered in the output stage, where output stalls can hold it.
// Reset clears all record state at once.
// A two-entry queue lets the input keep flowing while the output stalls, until it fills.
module record_deframer_crc_check import rdcrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rdcrc_in_if.sink    in_s,
  rdcrc_out_if.source out_m
);

  logic    fq_valid, fq_ready, qb_valid, qb_ready, r_valid;
  work_t   fq_data, qb_data;
  result_t r_data;

  rdcrc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_s.valid), .in_byte_i(in_s.in_byte), .in_end_i(in_s.stream_end),
    .in_ready_o(in_s.ready),
    .w_valid_o(fq_valid), .w_data_o(fq_data), .w_ready_i(fq_ready)
  );

  rdcrc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(fq_valid), .push_data_i(fq_data), .ready_o(fq_ready),
    .valid_o(qb_valid), .pop_data_o(qb_data), .pop_i(qb_valid & qb_ready)
  );

  rdcrc_back u_back (
    .clk_i, .rst_ni,
    .w_valid_i(qb_valid), .w_data_i(qb_data), .w_ready_o(qb_ready),
    .r_valid_o(r_valid), .r_data_o(r_data), .r_ready_i(out_m.ready)
  );

  // Drive the result channel.
  assign out_m.valid          = r_valid;
  assign out_m.out_byte       = r_data.out_byte;
  assign out_m.has_byte       = r_data.has_byte;
  assign out_m.is_extra       = r_data.is_extra;
  assign out_m.record_done    = r_data.record_done;
  assign out_m.status         = r_data.status;
  assign out_m.format_version = r_data.format_version;
  assign out_m.crypto_word    = r_data.crypto_word;
  assign out_m.payload_length = r_data.payload_length;
  assign out_m.extra_length   = r_data.extra_length;
  assign out_m.record_length  = r_data.record_length;

endmodule

// ===== tb/rdcrc_tb_if.sv =====
// Testbench package: expected-result type shared by the deframer checks.
`timescale 1ns / 100ps
package rdcrc_tb_pkg;
  import rdcrc_pkg::*;

  // One expected record-stream result.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        is_extra;
    logic        record_done;
    logic [2:0]  status;
    logic [1:0]  format_version;
    logic [31:0] crypto_word;
    logic [31:0] payload_length;
    logic [31:0] extra_length;
    logic [31:0] record_length;
  } deframe_result_t;
endpackage

// ===== tb/record_deframer_crc_check_tb.sv =====
// Testbench: drives record byte streams into the deframer and checks every result.
`timescale 1ns / 100ps
module record_deframer_crc_check_tb;
  import rdcrc_pkg::*;
  import rdcrc_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  rdcrc_in_if  in_ch();
  rdcrc_out_if out_ch();

  record_deframer_crc_check u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_ch.sink),
    .out_m (out_ch.source)
  );

  // Deframer mirror state
  phase_e      mir_phase;
  logic [4:0]  mir_hdr_cnt;
  logic [31:0] mir_shift;
  logic [1:0]  mir_version;
  logic [31:0] mir_crypto, mir_plen, mir_crc_field, mir_xlen, mir_left, mir_crc, mir_count;

  deframe_result_t expected_results[$];
  int mismatch_count;
  int send_idle_pct, recv_stall_pct;

  // Clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic clear_record();
    mir_phase = PH_HEADER; mir_hdr_cnt = '0; mir_shift = '0; mir_version = '0;
    mir_crypto = '0; mir_plen = '0; mir_crc_field = '0; mir_xlen = '0;
    mir_left = '0; mir_crc = '1; mir_count = '0;
  endtask

  // Reflected CRC-32 advance, bitwise.
  function automatic logic [31:0] crc_advance(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  function automatic status_e record_verdict();
    if (mir_plen == 0 || mir_crc_field == 0) return ST_UNVERIF;
    return ((mir_crc ^ 32'hFFFFFFFF) == mir_crc_field) ? ST_GOOD : ST_CRC_BAD;
  endfunction

  // Predict the result of one accepted byte.
  task automatic predict_byte(logic [7:0] b, logic last);
    logic has, isx, done;
    status_e st;
    logic [31:0] k;
    deframe_result_t r;
    has = 0; isx = 0; done = 0; st = ST_OPEN;
    if (mir_count != '1) mir_count++;
    if (mir_phase != PH_HEADER) begin
      has = 1;
      isx = (mir_phase == PH_EXTRA);
      if (!isx) mir_crc = crc_advance(mir_crc, b);
      mir_left--;
      if (mir_left == 0) begin
        if (!isx && mir_xlen != 0) begin
          mir_phase = PH_EXTRA; mir_left = mir_xlen;
        end else begin
          done = 1; st = record_verdict();
        end
      end
    end else begin
      mir_shift = (mir_shift >> 8) | ({24'd0, b} << 24);
      mir_hdr_cnt = mir_hdr_cnt + 1;
      if (mir_hdr_cnt == 4) begin
        if (mir_shift[15:0] == HeaderIdV2 && mir_shift[31:16] == 2) mir_version = 2;
        else if (mir_shift[15:0] == 1) mir_version = 1;
        else begin
          done = 1; st = ST_BAD_HDR;
        end
      end else if (mir_hdr_cnt >= 8 && mir_hdr_cnt[1:0] == 0) begin
        k = (mir_hdr_cnt - 8) >> 2;
        if (mir_version == 1) k++;
        case (k)
          0: mir_crypto = mir_shift;
          1: mir_plen = mir_shift;
          2: mir_crc_field = mir_shift;
          default: begin
            mir_xlen = mir_shift;
            if (mir_plen != 0) begin
              mir_phase = PH_PAYLOAD; mir_left = mir_plen;
            end else if (mir_xlen != 0) begin
              mir_phase = PH_EXTRA; mir_left = mir_xlen;
            end else begin
              done = 1; st = record_verdict();
            end
          end
        endcase
      end
    end
    if (!done && last) begin
      done = 1; st = ST_TRUNCATED;
    end
    if (has || done) begin
      r.out_byte = has ? b : 8'd0;
      r.has_byte = has;
      r.is_extra = isx;
      r.record_done = done;
      r.status = st;
      r.format_version = (st == ST_BAD_HDR) ? 2'd0 : mir_version;
      r.crypto_word = mir_crypto;
      r.payload_length = mir_plen;
      r.extra_length = mir_xlen;
      r.record_length = mir_count;
      expected_results.push_back(r);
      if (done) clear_record();
    end
  endtask

  // Send one byte; inputs change on the falling edge.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_ch.valid = 1; in_ch.in_byte = b; in_ch.stream_end = last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_byte(b, last);
    @(negedge clk_i);
    in_ch.valid = 0;
  endtask

  task automatic send_word(logic [31:0] w, int nbytes = 4);
    for (int i = 0; i < nbytes; i++) send_byte(w[8*i +: 8], 1'b0);
  endtask

  // Send a full record; body content random, CRC right, wrong or zero as asked.
  task automatic send_record(int ver, int plen, int xlen, int crc_mode, logic [31:0] crypto);
    logic [7:0] body[$];
    logic [31:0] c, crc_field;
    c = '1;
    for (int i = 0; i < plen; i++) begin
      body.push_back($urandom);
      c = crc_advance(c, body[i]);
    end
    c ^= '1;
    crc_field = (crc_mode == 0) ? c : (crc_mode == 1) ? (c ^ (1 << $urandom_range(31))) : 0;
    if (ver == 2) begin
      send_word({16'd2, HeaderIdV2}); send_word(crypto);
    end else begin
      send_word({16'($urandom_range(16'hFFFF)), 16'd1});
    end
    send_word(plen); send_word(crc_field); send_word(xlen);
    foreach (body[i]) send_byte(body[i], 1'b0);
    for (int i = 0; i < xlen; i++) send_byte($urandom, 1'b0);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    deframe_result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.record_length, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.out_byte !== e.out_byte) report_mismatch("out_byte", out_ch.out_byte, e.out_byte);
        if (out_ch.has_byte !== e.has_byte) report_mismatch("has_byte", out_ch.has_byte, e.has_byte);
        if (out_ch.is_extra !== e.is_extra) report_mismatch("is_extra", out_ch.is_extra, e.is_extra);
        if (out_ch.record_done !== e.record_done)
          report_mismatch("record_done", out_ch.record_done, e.record_done);
        if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
        if (out_ch.format_version !== e.format_version)
          report_mismatch("format_version", out_ch.format_version, e.format_version);
        if (out_ch.crypto_word !== e.crypto_word)
          report_mismatch("crypto_word", out_ch.crypto_word, e.crypto_word);
        if (out_ch.payload_length !== e.payload_length)
          report_mismatch("payload_length", out_ch.payload_length, e.payload_length);
        if (out_ch.extra_length !== e.extra_length)
          report_mismatch("extra_length", out_ch.extra_length, e.extra_length);
        if (out_ch.record_length !== e.record_length)
          report_mismatch("record_length", out_ch.record_length, e.record_length);
      end
    end
  end

  // Stall the result channel at random.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_record(2, 1, 0, 0, 32'hFFFFFFFF);
    send_record(2, 3, 2, 1, 32'h0);
    send_record(1, 2, 1, 0, 0);
    send_record(2, 0, 0, 0, 32'h1);
    send_record(1, 0, 2, 0, 0);
    send_record(2, 2, 0, 2, 32'h12345678);
    // Bad header, then truncation inside a header and inside a body.
    send_word(32'hFFFF_00FF);
    send_word({16'd2, HeaderIdV2}); send_byte(8'h00, 1'b1);
    send_word({16'd0, 16'd1}); send_word(5); send_word(0); send_word(0);
    send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b1);
    wait_drained();
    repeat (5) @(negedge clk_i);
  endtask

  task automatic test_random(int n_bytes);
    int sent_before, kind;
    sent_before = 0;
    for (int r = 0; sent_before < n_bytes; r++) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        send_record($urandom_range(1) ? 2 : 1, $urandom_range(12), $urandom_range(4),
                    $urandom_range(2), $urandom);
        sent_before += 30;
      end else if (kind == 7) begin
        send_word($urandom);
        sent_before += 4;
      end else begin
        for (int i = $urandom_range(1, 10); i > 0; i--) send_byte($urandom, 1'b0);
        send_byte($urandom, 1'b1);
        sent_before += 6;
      end
      if (r == 5) begin
        wait_drained();
        repeat (5) @(negedge clk_i);
      end
    end
    wait_drained();
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct = 10; recv_stall_pct = 63;
    clear_record();
    in_ch.valid = 0; in_ch.in_byte = 0; in_ch.stream_end = 0;
    out_ch.ready = 0;
    rst_ni = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_random(650);
    send_idle_pct = 63; recv_stall_pct = 10;
    test_random(650);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(600);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/rdcrc_pkg.sv
rtl/core/rdcrc_if.sv
rtl/core/rdcrc_front.sv
rtl/core/rdcrc_queue.sv
rtl/core/rdcrc_back.sv
rtl/core/record_deframer_crc_check.sv
tb/rdcrc_tb_if.sv
tb/record_deframer_crc_check_tb.sv
